/* hdl/fifo_queue_with_value_removal_assert.svh */
`ifndef FIFO_QUEUE_WITH_VALUE_REMOVAL_ASSERT_SVH
`define FIFO_QUEUE_WITH_VALUE_REMOVAL_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define FQVR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define FQVR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/fqvr_pkg.sv */
package fqvr_pkg;

    localparam int DEPTH   = 16;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int DW      = 32;
    localparam int ENTRY_W = 5;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_PEEK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } t_state;

    typedef struct packed {
        t_op                   operation;
        logic signed [DW-1:0]  value;
    } t_req;

    typedef struct packed {
        t_status               status;
        logic                  found;
        logic signed [DW-1:0]  head_value;
        logic [ENTRY_W-1:0]    entry_count;
    } t_res;

    typedef struct packed {
        logic           we;
        logic [AW-1:0]  waddr;
        logic [DW-1:0]  wdata;
        logic           re;
        logic [AW-1:0]  raddr;
    } t_mem_req;

    // result word, head forced to zero when nothing is held
    function automatic t_res make_res(t_status st, logic fnd, logic [DW-1:0] hd,
                                      logic [CW-1:0] cnt);
        t_res                 res;
        logic [CW+ENTRY_W-1:0] ext;
        ext              = {{ENTRY_W{1'b0}}, cnt};
        res.status       = st;
        res.found        = fnd;
        res.head_value   = (cnt == '0) ? '0 : hd;
        res.entry_count  = ext[ENTRY_W-1:0];
        return res;
    endfunction

endpackage

/* hdl/fqvr_ram.sv */
module fqvr_ram
    import fqvr_pkg::*;
(
    input  logic           i_clk,
    input  t_mem_req       i_mem,
    output logic [DW-1:0]  o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_mem.we) begin
            r_mem[i_mem.waddr] <= i_mem.wdata;
        end
        if (i_mem.re) begin
            r_rd_data <= r_mem[i_mem.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/fqvr_ctrl.sv */
`include "fifo_queue_with_value_removal_assert.svh"

module fqvr_ctrl
    import fqvr_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  t_req           i_req,
    output logic           o_busy,
    output logic           o_strobe,
    output t_res           o_res,
    output t_mem_req       o_mem,
    input  logic [DW-1:0]  i_rd_data
);

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count;
    logic [DW-1:0]  r_head;
    logic [DW-1:0]  r_val;
    t_op            r_op;
    logic [CW-1:0]  r_idx;
    logic [CW-1:0]  r_cmp_idx;
    logic           r_pend;
    logic           r_strobe;
    t_res           r_res;

    logic           accept;
    logic           full;
    logic           issue;
    logic           match;
    logic           last_cmp;
    logic [CW-1:0]  wr_idx;
    logic [CW-1:0]  count_m1;

    assign accept   = i_start && (r_state == S_IDLE);
    assign full     = (r_count == CW'(DEPTH));
    assign issue    = (r_idx < r_count);
    assign count_m1 = r_count - CW'(1);
    assign match    = r_pend && (i_rd_data == r_val);
    assign last_cmp = r_pend && (r_cmp_idx == count_m1);
    assign wr_idx   = r_cmp_idx - CW'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_req.operation inside {OP_REMOVE, OP_SEARCH})
                    && (r_count != '0)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (match) begin
                    n_state = (r_op == OP_REMOVE) ? S_SHIFT : S_IDLE;
                end else if (last_cmp) begin
                    n_state = S_IDLE;
                end
            end
            S_SHIFT: begin
                if (!issue && !r_pend) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs: memory port and busy
    always_comb begin
        o_mem       = '0;
        o_busy      = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (accept && (i_req.operation == OP_PUSH) && !full) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_count[AW-1:0];
                    o_mem.wdata = i_req.value;
                end
            end
            S_SCAN: begin
                o_mem.re    = issue;
                o_mem.raddr = r_idx[AW-1:0];
            end
            S_SHIFT: begin
                o_mem.re    = issue;
                o_mem.raddr = r_idx[AW-1:0];
                o_mem.we    = r_pend;
                o_mem.waddr = wr_idx[AW-1:0];
                o_mem.wdata = i_rd_data;
            end
            default: o_busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;
            if (r_state == S_IDLE) begin
                if (accept) begin
                    r_op   <= i_req.operation;
                    r_val  <= i_req.value;
                    r_idx  <= '0;
                    r_pend <= 1'b0;
                    unique case (i_req.operation)
                        OP_PUSH: begin
                            r_strobe <= 1'b1;
                            if (full) begin
                                r_res <= make_res(ST_FULL, 1'b0, r_head, r_count);
                            end else begin
                                r_count <= r_count + CW'(1);
                                if (r_count == '0) begin
                                    r_head <= i_req.value;
                                    r_res  <= make_res(ST_OK, 1'b0, i_req.value,
                                                       r_count + CW'(1));
                                end else begin
                                    r_res  <= make_res(ST_OK, 1'b0, r_head,
                                                       r_count + CW'(1));
                                end
                            end
                        end
                        OP_PEEK: begin
                            r_strobe <= 1'b1;
                            r_res    <= make_res((r_count == '0) ? ST_EMPTY : ST_OK,
                                                 1'b0, r_head, r_count);
                        end
                        OP_REMOVE, OP_SEARCH: begin
                            if (r_count == '0) begin
                                r_strobe <= 1'b1;
                                r_res    <= make_res(ST_EMPTY, 1'b0, r_head, r_count);
                            end
                        end
                        default: r_strobe <= 1'b0;
                    endcase
                end
            end else begin
                // read pipeline shared by scan and shift
                if (issue) begin
                    r_idx     <= r_idx + CW'(1);
                    r_cmp_idx <= r_idx;
                    r_pend    <= 1'b1;
                end else begin
                    r_pend    <= 1'b0;
                end
                if (r_state == S_SCAN) begin
                    if (match) begin
                        if (r_op == OP_REMOVE) begin
                            r_idx  <= r_cmp_idx + CW'(1);
                            r_pend <= 1'b0;
                        end else begin
                            r_strobe <= 1'b1;
                            r_res    <= make_res(ST_OK, 1'b1, r_head, r_count);
                        end
                    end else if (last_cmp) begin
                        r_strobe <= 1'b1;
                        r_res    <= make_res(ST_NOT_FOUND, 1'b0, r_head, r_count);
                    end
                end else begin
                    if (r_pend && (wr_idx == '0)) begin
                        r_head <= i_rd_data;
                    end
                    if (!issue && !r_pend) begin
                        r_count  <= count_m1;
                        r_strobe <= 1'b1;
                        r_res    <= make_res(ST_OK, 1'b1, r_head, count_m1);
                    end
                end
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    `FQVR_ASSERT_NEXT(a_quick_ops, accept && ((i_req.operation == OP_PUSH) || (i_req.operation == OP_PEEK)), r_strobe, "push or peek gave no result in the next cycle")
    `FQVR_ASSERT(a_strobe_idle, !r_strobe || (r_state == S_IDLE), "result shown while still busy")
    `FQVR_ASSERT(a_empty_count, !(r_strobe && (r_res.status == ST_EMPTY)) || (r_res.entry_count == '0), "empty status with entries held")
    `FQVR_ASSERT(a_rw_apart, !(o_mem.we && o_mem.re) || (o_mem.waddr != o_mem.raddr), "read and write hit the same entry")
    `FQVR_ASSERT(a_wr_in_range, !o_mem.we || (CW'(o_mem.waddr) <= r_count), "write beyond the tail")

endmodule

/* hdl/fifo_queue_with_value_removal.sv */
// push and peek: result strobe in the cycle after start, next start accepted at once
// search: compares entries from the head until the first match (at most the count)
// remove: search, then shifts the entries after the match down by one (entry 0 = head),
// with no entry moved when the match is the tail entry; walks run one entry per cycle
// synchronous active-low reset empties the queue; entry memory keeps its contents
// busy falls with the strobe; results last one cycle and cannot be held off
module fifo_queue_with_value_removal
    import fqvr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_req  i_req,
    output logic  busy,
    output logic  strobe,
    output t_res  o_res
);

    // memory port between controller and entry store
    t_mem_req       mem_req;
    logic [DW-1:0]  mem_rd_data;

    // controller: decodes each transaction, walks the store for search and
    // remove, shifts the tail down by one to close the gap after a removal,
    // and keeps the count and a copy of the head entry in registers
    fqvr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_req     (i_req),
        .o_busy    (busy),
        .o_strobe  (strobe),
        .o_res     (o_res),
        .o_mem     (mem_req),
        .i_rd_data (mem_rd_data)
    );

    // entry store: one write and one registered read per cycle,
    // entry 0 is always the queue head
    fqvr_ram u_ram (
        .i_clk     (i_clk),
        .i_mem     (mem_req),
        .o_rd_data (mem_rd_data)
    );

endmodule
